FILE: hw/rtl/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg
// Codes shared by the sorted free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package sfla_pkg;
  localparam logic       FUNC_ALLOC = 1'b0;
  localparam logic       FUNC_FREE  = 1'b1;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_NOFIT = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic [1:0] POL_BEST   = 2'd1;
  localparam logic [1:0] POL_WORST  = 2'd2;

  localparam logic       CFG_FIT    = 1'b0;
  localparam logic       CFG_ARENA  = 1'b1;

  localparam int         REG_W      = 12;
  localparam int         SIZE_W     = 13;
endpackage
`default_nettype wire

FILE: hw/rtl/sfla_if.sv
// ----------------------------------------------------------------------------
// sfla_req_if / sfla_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface sfla_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [11:0] alloc_size;
  logic [11:0] payload_offset;
  modport source (output valid, func, alloc_size, payload_offset, input ready);
  modport sink   (input valid, func, alloc_size, payload_offset, output ready);
endinterface

interface sfla_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] result_offset;
  logic [1:0]  status;
  modport source (output valid, result_offset, status, input ready);
  modport sink   (input valid, result_offset, status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sfla_ram.sv
// ----------------------------------------------------------------------------
// sfla_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/sorted_free_list_allocator.sv
// ----------------------------------------------------------------------------
// sorted_free_list_allocator
// Address-ordered free-list allocator (first/best/worst fit, coalescing free).
// ----------------------------------------------------------------------------
//  channel | dir | payload                               | handshake
//  in_ch   | in  | func, alloc_size, payload_offset      | valid/ready
//  out_ch  | out | result_offset, status                 | valid/ready
//  cfg_*   | in  | cfg_idx, cfg_wdata                    | cfg_we
//
// Allocate: walks the free nodes (S_AWALK/S_AEVAL), then S_ADONE, S_ASPL1/2 on a split,
// S_ALINK and S_FIN. Free: walks the nodes below the block, then S_FRDB, S_FRDC, S_FWP,
// S_FIN; an out-of-range free goes straight to S_FIN.
// The walk is bound by the single read port of the header RAM.
// After reset and after an arena_units write, the S_INIT state initializes entry 0.
// One result register; the next request is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_free_list_allocator
  import sfla_pkg::*;
#(
  parameter int ARENA_UNITS  = 4096,
  parameter int HEADER_UNITS = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sfla_req_if.sink               in_ch,
  sfla_rsp_if.source             out_ch,
  input  wire logic              cfg_we,
  input  wire logic              cfg_idx,
  input  wire logic [REG_W-1:0]  cfg_wdata
);
  localparam int AW     = $clog2(ARENA_UNITS);
  localparam int CW     = ((AW > SIZE_W) ? AW : SIZE_W) + 2;
  localparam int MAX_AU = (ARENA_UNITS - HEADER_UNITS > 4095) ? 4095
                          : ARENA_UNITS - HEADER_UNITS;
  localparam int HW     = 1 + AW + SIZE_W;

  typedef struct packed {
    logic              link;
    logic [AW-1:0]     next;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_AWALK, S_AEVAL, S_ADONE, S_ASPL1, S_ASPL2, S_ALINK,
    S_FWALK, S_FEVAL, S_FRDB, S_FRDC, S_FWP, S_FIN
  } state_t;

  state_t            state_r;
  logic [1:0]        fit_r;
  logic [REG_W-1:0]  arena_r;
  logic              head_v_r;
  logic [AW-1:0]     head_r;
  logic [REG_W-1:0]  size_r;
  logic [AW-1:0]     blk_r;
  logic              cv_r, pv_r, have_r, chp_r, chlink_r;
  logic [AW-1:0]     cur_r, prev_r, ch_r, chprev_r, chnext_r;
  logic [SIZE_W-1:0] psize_r, chsize_r, chpsize_r, bsize_r;
  logic [AW:0]       steps_r;
  hdr_t              p_r;
  logic              out_v_r;
  logic [REG_W-1:0]  out_off_r, res_off_r;
  logic [1:0]        out_st_r, res_st_r;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  hdr_t              wdata, rd;
  logic [HW-1:0]     rdata;

  sfla_ram #(.WIDTH(HW), .DEPTH(ARENA_UNITS)) u_hdr (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd = hdr_t'(rdata);

  logic              walk_go, fwalk_go, take, split, mrg_c, mrg_p, arena_wr;
  logic [SIZE_W:0]   need;
  logic [CW-1:0]     b_end, p_end;
  logic [AW-1:0]     rem;
  logic [12:0]       at_m;
  hdr_t              b_new, p_new;

  assign arena_wr = cfg_we && (cfg_idx == CFG_ARENA);

  always_comb begin
    walk_go  = cv_r && (steps_r < (AW+1)'(ARENA_UNITS));
    fwalk_go = walk_go && (cur_r < blk_r);
    if (fit_r == POL_BEST) begin
      take = !have_r || (rd.size < chsize_r);
    end else if (fit_r == POL_WORST) begin
      take = !have_r || (rd.size > chsize_r);
    end else begin
      take = 1'b1;
    end
    take  = take && (rd.size >= SIZE_W'(size_r));
    need  = (SIZE_W+1)'(size_r) + (SIZE_W+1)'(HEADER_UNITS + 1);
    split = (SIZE_W+1)'(chsize_r) >= need;
    rem   = AW'(CW'(ch_r) + CW'(HEADER_UNITS) + CW'(size_r));
    at_m  = 13'(in_ch.payload_offset) - 13'(HEADER_UNITS);
    b_end = CW'(blk_r) + CW'(HEADER_UNITS) + CW'(bsize_r);
    mrg_c = cv_r && (b_end == CW'(cur_r));
    b_new.link = mrg_c ? rd.link : cv_r;
    b_new.next = mrg_c ? rd.next : cur_r;
    b_new.size = mrg_c ? SIZE_W'(bsize_r + SIZE_W'(HEADER_UNITS) + rd.size) : bsize_r;
    p_end = CW'(prev_r) + CW'(HEADER_UNITS) + CW'(psize_r);
    mrg_p = pv_r && (p_end == CW'(blk_r));
    p_new.link = mrg_p ? b_new.link : 1'b1;
    p_new.next = mrg_p ? b_new.next : blk_r;
    p_new.size = mrg_p ? SIZE_W'(psize_r + SIZE_W'(HEADER_UNITS) + b_new.size)
                       : psize_r;
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = cur_r;
    case (state_r)
      S_INIT: begin
        we    = 1'b1;
        wdata = '{link: 1'b0, next: '0, size: SIZE_W'(arena_r)};
      end
      S_FWALK: begin
        raddr = fwalk_go ? cur_r : blk_r;
      end
      S_ASPL1: begin
        we    = 1'b1;
        waddr = rem;
        wdata = '{link: chlink_r, next: chnext_r,
                  size: SIZE_W'(chsize_r - SIZE_W'(size_r) - SIZE_W'(HEADER_UNITS))};
      end
      S_ASPL2: begin
        we    = 1'b1;
        waddr = ch_r;
        wdata = '{link: chlink_r, next: chnext_r, size: SIZE_W'(size_r)};
      end
      S_ALINK: begin
        we    = chp_r;
        waddr = chprev_r;
        wdata = p_r;
      end
      S_FRDC: begin
        we    = 1'b1;
        waddr = blk_r;
        wdata = b_new;
      end
      S_FWP: begin
        we    = pv_r;
        waddr = prev_r;
        wdata = p_r;
      end
      default: ;
    endcase
  end

  assign in_ch.ready          = (state_r == S_IDLE) && !arena_wr;
  assign out_ch.valid         = out_v_r;
  assign out_ch.result_offset = out_off_r;
  assign out_ch.status        = out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      fit_r    <= 2'd0;
      arena_r  <= REG_W'(MAX_AU);
      head_v_r <= 1'b1;
      head_r   <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (out_ch.ready && state_r != S_FIN) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we && cfg_idx == CFG_FIT) begin
        fit_r <= cfg_wdata[1:0];
      end
      if (arena_wr) begin
        arena_r  <= (cfg_wdata > REG_W'(MAX_AU)) ? REG_W'(MAX_AU) : cfg_wdata;
        head_v_r <= 1'b1;
        head_r   <= '0;
        state_r  <= S_INIT;
      end else begin
        case (state_r)
          S_INIT: begin
            state_r <= S_IDLE;
          end
          S_IDLE: begin
            if (in_ch.valid) begin
              cv_r    <= head_v_r;
              cur_r   <= head_r;
              pv_r    <= 1'b0;
              have_r  <= 1'b0;
              steps_r <= '0;
              size_r  <= in_ch.alloc_size;
              blk_r   <= AW'(at_m);
              if (in_ch.func == FUNC_ALLOC) begin
                state_r <= S_AWALK;
              end else if (in_ch.payload_offset < REG_W'(HEADER_UNITS) ||
                           at_m >= 13'(arena_r)) begin
                res_off_r <= '0;
                res_st_r  <= STAT_RANGE;
                state_r   <= S_FIN;
              end else begin
                state_r <= S_FWALK;
              end
            end
          end
          S_AWALK: begin
            state_r <= walk_go ? S_AEVAL : S_ADONE;
          end
          S_AEVAL: begin
            steps_r <= steps_r + 1'b1;
            pv_r    <= 1'b1;
            prev_r  <= cur_r;
            psize_r <= rd.size;
            cv_r    <= rd.link;
            cur_r   <= rd.next;
            state_r <= S_AWALK;
            if (take) begin
              have_r    <= 1'b1;
              ch_r      <= cur_r;
              chsize_r  <= rd.size;
              chp_r     <= pv_r;
              chprev_r  <= prev_r;
              chpsize_r <= psize_r;
              chlink_r  <= rd.link;
              chnext_r  <= rd.next;
              if (fit_r != POL_BEST && fit_r != POL_WORST) begin
                state_r <= S_ADONE;
              end
            end
          end
          S_ADONE: begin
            res_off_r <= have_r ? REG_W'(CW'(ch_r) + CW'(HEADER_UNITS)) : '0;
            res_st_r  <= have_r ? STAT_DONE : STAT_NOFIT;
            p_r.size  <= chpsize_r;
            if (!have_r) begin
              state_r <= S_FIN;
            end else if (split) begin
              p_r.link <= 1'b1;
              p_r.next <= rem;
              state_r  <= S_ASPL1;
            end else begin
              p_r.link <= chlink_r;
              p_r.next <= chnext_r;
              state_r  <= S_ALINK;
            end
          end
          S_ASPL1: state_r <= S_ASPL2;
          S_ASPL2: state_r <= S_ALINK;
          S_ALINK: begin
            if (!chp_r) begin
              head_v_r <= p_r.link;
              head_r   <= p_r.next;
            end
            state_r <= S_FIN;
          end
          S_FWALK: begin
            state_r <= fwalk_go ? S_FEVAL : S_FRDB;
          end
          S_FEVAL: begin
            steps_r <= steps_r + 1'b1;
            pv_r    <= 1'b1;
            prev_r  <= cur_r;
            psize_r <= rd.size;
            cv_r    <= rd.link;
            cur_r   <= rd.next;
            state_r <= S_FWALK;
          end
          S_FRDB: begin
            bsize_r <= rd.size;
            state_r <= S_FRDC;
          end
          S_FRDC: begin
            p_r     <= p_new;
            state_r <= S_FWP;
          end
          S_FWP: begin
            if (!pv_r) begin
              head_v_r <= 1'b1;
              head_r   <= blk_r;
            end
            res_off_r <= '0;
            res_st_r  <= STAT_DONE;
            state_r   <= S_FIN;
          end
          S_FIN: begin
            if (!out_v_r || out_ch.ready) begin
              out_v_r   <= 1'b1;
              out_off_r <= res_off_r;
              out_st_r  <= res_st_r;
              state_r   <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

FILE: bench/sfla_tb_if.sv
// ----------------------------------------------------------------------------
// sfla_tb_if
// Includes nothing; the channel interfaces come from the RTL tree.
// ----------------------------------------------------------------------------
// The request and result channels use sfla_req_if and sfla_rsp_if as
// declared beside the RTL package.

FILE: bench/sfla_checker.sv
// ----------------------------------------------------------------------------
// sfla_checker
// Tracks the allocator's free list, predicts every result and compares it.
// ----------------------------------------------------------------------------
module sfla_checker
  import sfla_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic        req_func,
  input  logic [11:0] req_size,
  input  logic [11:0] req_offset,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [11:0] rsp_offset,
  input  logic [1:0]  rsp_status,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [11:0] cfg_wdata,
  output int          pending,
  output int          errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNITS = 4096;
  localparam int HDR   = 2;
  localparam int MAXA  = UNITS - HDR;

  typedef struct packed {
    logic [11:0] offset;
    logic [1:0]  status;
  } result_t;

  logic        lnk  [UNITS];
  int unsigned nxt  [UNITS];
  int unsigned sz   [UNITS];
  logic        head_ok;
  int unsigned head;
  logic [1:0]  policy;
  int unsigned arena;
  result_t     expected_q[$];

  function automatic int unsigned ix(int unsigned a);
    return a % UNITS;
  endfunction

  function automatic void relink(logic hp, int unsigned p, logic v, int unsigned t);
    if (hp) begin
      lnk[ix(p)] = v;
      nxt[ix(p)] = t;
    end else begin
      head_ok = v;
      head = t;
    end
  endfunction

  function automatic void reinit();
    lnk[0] = 1'b0;
    nxt[0] = 0;
    sz[0] = arena;
    head_ok = 1'b1;
    head = 0;
  endfunction

  function automatic result_t allocate(int unsigned want);
    logic cv, have, pv, chp, take;
    int unsigned cur, prv, ch, chprev, chsize, steps, cs, rem;
    result_t r;
    cv = head_ok; have = 0; pv = 0; chp = 0;
    cur = head; prv = 0; ch = 0; chprev = 0; chsize = 0; steps = 0;
    while (cv && steps < UNITS) begin
      cs = sz[ix(cur)];
      steps++;
      if (cs >= want) begin
        if (policy == POL_BEST) take = !have || cs < chsize;
        else if (policy == POL_WORST) take = !have || cs > chsize;
        else take = 1'b1;
        if (take) begin
          have = 1; ch = cur; chsize = cs; chp = pv; chprev = prv;
          if (policy != POL_BEST && policy != POL_WORST) break;
        end
      end
      pv = 1; prv = cur;
      cv = lnk[ix(cur)];
      cur = nxt[ix(cur)];
    end
    if (!have) begin
      r.offset = '0;
      r.status = STAT_NOFIT;
      return r;
    end
    if (chsize >= want + HDR + 1) begin
      rem = ch + HDR + want;
      lnk[ix(rem)] = lnk[ix(ch)];
      nxt[ix(rem)] = nxt[ix(ch)];
      sz[ix(rem)] = chsize - want - HDR;
      relink(chp, chprev, 1'b1, rem);
      sz[ix(ch)] = want;
    end else begin
      relink(chp, chprev, lnk[ix(ch)], nxt[ix(ch)]);
    end
    r.offset = 12'(ch + HDR);
    r.status = STAT_DONE;
    return r;
  endfunction

  function automatic result_t release_block(int unsigned at);
    logic cv, pv;
    int unsigned blk, cur, prv, steps, bi, ci, pi;
    result_t r;
    r.offset = '0;
    if (at < HDR || at - HDR >= arena) begin
      r.status = STAT_RANGE;
      return r;
    end
    blk = at - HDR; bi = ix(blk);
    cur = head; prv = 0; steps = 0; cv = head_ok; pv = 0;
    while (cv && cur < blk && steps < UNITS) begin
      steps++;
      pv = 1; prv = cur;
      cv = lnk[ix(cur)];
      cur = nxt[ix(cur)];
    end
    lnk[bi] = cv;
    nxt[bi] = cur;
    relink(pv, prv, 1'b1, blk);
    if (cv && blk + HDR + sz[bi] == cur) begin
      ci = ix(cur);
      sz[bi] = sz[bi] + HDR + sz[ci];
      lnk[bi] = lnk[ci];
      nxt[bi] = nxt[ci];
    end
    if (pv) begin
      pi = ix(prv);
      if (prv + HDR + sz[pi] == blk) begin
        sz[pi] = sz[pi] + HDR + sz[bi];
        lnk[pi] = lnk[bi];
        nxt[pi] = nxt[bi];
      end
    end
    r.status = STAT_DONE;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < UNITS; i++) begin
        lnk[i] = 0; nxt[i] = 0; sz[i] = 0;
      end
      policy = '0;
      arena = MAXA;
      reinit();
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_FIT) policy = cfg_wdata[1:0];
        else begin
          arena = (cfg_wdata > MAXA) ? MAXA : cfg_wdata;
          reinit();
        end
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: offset %0d status %0d", rsp_offset, rsp_status);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.offset !== rsp_offset || exp_r.status !== rsp_status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected offset %0d status %0d, got offset %0d status %0d",
                       exp_r.offset, exp_r.status, rsp_offset, rsp_status);
          end
        end
      end
      if (req_valid && req_ready) begin
        if (req_func == FUNC_ALLOC)
          expected_q.insert(expected_q.size(), allocate(req_size));
        else
          expected_q.insert(expected_q.size(), release_block(req_offset));
      end
    end
    pending = expected_q.size();
  end
endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives allocate/free traffic with random gaps, stalls and configuration
// phases into the allocator; a checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb
  import sfla_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic        cfg_idx = CFG_FIT;
  logic [11:0] cfg_wdata = '0;
  int          pending, errors;
  int unsigned cycles = 0;
  bit          out_long = 0;
  logic [11:0] live_q[$];

  sfla_req_if in_ch ();
  sfla_rsp_if out_ch ();

  sorted_free_list_allocator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  sfla_checker chk (
    .clk(clk), .rst_n(rst_n),
    .req_valid(in_ch.valid), .req_ready(in_ch.ready), .req_func(in_ch.func),
    .req_size(in_ch.alloc_size), .req_offset(in_ch.payload_offset),
    .rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready),
    .rsp_offset(out_ch.result_offset), .rsp_status(out_ch.status),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .pending(pending), .errors(errors)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.func = FUNC_ALLOC;
    in_ch.alloc_size = '0;
    in_ch.payload_offset = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 60000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // track allocated offsets from results so frees hit real blocks
  always @(posedge clk)
    if (rst_n && out_ch.valid && out_ch.ready && out_ch.status == STAT_DONE
        && out_ch.result_offset != 0)
      live_q.insert(live_q.size(), out_ch.result_offset);

  initial begin
    int w;
    @(negedge clk);
    forever begin
      if (out_long) begin
        out_ch.ready <= 0;
        repeat (300) @(negedge clk);
        out_long = 0;
      end
      w = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
      if (w > 0) begin
        out_ch.ready <= 0;
        repeat (w) @(negedge clk);
      end
      out_ch.ready <= 1;
      @(negedge clk);
    end
  end

  task automatic send(logic f, logic [11:0] s, logic [11:0] o);
    int w;
    w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
    if (w > 0) begin
      in_ch.valid <= 0;
      repeat (w) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.func <= f;
    in_ch.alloc_size <= s;
    in_ch.payload_offset <= o;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic i, logic [11:0] d);
    cfg_we <= 1; cfg_idx <= i; cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic free_one();
    int k;
    logic [11:0] o;
    if (live_q.size() == 0) begin
      send(FUNC_FREE, 12'($urandom), 12'($urandom_range(0, 1)));
      return;
    end
    k = $urandom_range(0, live_q.size() - 1);
    o = live_q[k];
    live_q.delete(k);
    send(FUNC_FREE, 12'($urandom), o);
  endtask

  task automatic random_phase(int n, int unsigned maxsz);
    for (int i = 0; i < n; i++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) send(FUNC_ALLOC, 12'($urandom_range(0, maxsz)), 12'($urandom));
      else if (r < 92) free_one();
      else if (r < 96) send(FUNC_FREE, 12'($urandom), 12'($urandom_range(0, 1)));
      else send(FUNC_ALLOC, 12'($urandom_range(3000, 4095)), 12'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1;
    repeat (3) @(negedge clk);
    // directed: extremes, exact fit, no split, range errors, coalescing
    send(FUNC_ALLOC, 12'd0, 12'hFFF);
    send(FUNC_ALLOC, 12'd4095, 12'd0);
    send(FUNC_ALLOC, 12'd100, 12'd0);
    send(FUNC_ALLOC, 12'd200, 12'd0);
    send(FUNC_FREE, 12'd0, 12'd0);
    send(FUNC_FREE, 12'd0, 12'd1);
    drain();
    while (live_q.size() > 0) free_one();
    drain();
    write_reg(CFG_ARENA, 12'hFFF);
    send(FUNC_ALLOC, 12'd4094, 12'd0);
    send(FUNC_ALLOC, 12'd1, 12'd0);
    drain();
    while (live_q.size() > 0) free_one();
    drain();
    write_reg(CFG_ARENA, 12'd10);
    send(FUNC_ALLOC, 12'd8, 12'd0);
    send(FUNC_ALLOC, 12'd0, 12'd0);
    send(FUNC_FREE, 12'd0, 12'd4095);
    drain();
    live_q.delete();
    write_reg(CFG_ARENA, 12'd0);
    send(FUNC_ALLOC, 12'd0, 12'd0);
    send(FUNC_ALLOC, 12'd1, 12'd0);
    drain();
    live_q.delete();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_FIT, 12'(ph % 4));
      write_reg(CFG_ARENA, (ph == 3) ? 12'd60 : 12'($urandom_range(300, 4095)));
      live_q.delete();
      if (ph == 2) begin
        out_long = 1;
      end
      random_phase(200, (ph % 2) ? 40 : 400);
      drain();
    end
    write_reg(CFG_ARENA, 12'd0);
    drain();
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
